@@ hw/rtl/rag_pkg.sv @@
// Package for the region adjacency builder: field widths, beat structs,
// register indexes, request codes and parameter defaults.
// No dependencies.
package rag_pkg;

  localparam int MAX_LABELS_DEF = 64;
  localparam int MAX_WIDTH_DEF  = 1024;

  localparam int LABEL_W    = 8;
  localparam int LIM_W      = LABEL_W + 1;
  localparam int WIDTH_W    = 11;
  localparam int COUNT_W    = 7;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LABEL_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIAGONAL_ENABLE = 2'd2;

  localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RST     = 11'd1024;
  localparam logic [COUNT_W-1:0] LABEL_COUNT_RST     = 7'd64;
  localparam logic               DIAGONAL_ENABLE_RST = 1'b1;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // bit positions inside one pair entry
  localparam logic MARK_ORTH = 1'b0;
  localparam logic MARK_DIAG = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic               frame_start;
    logic [LABEL_W-1:0] label;
    logic [LABEL_W-1:0] other_label;
  } in_item_t;

  typedef struct packed {
    logic adjacent;
    logic diagonal_only;
    logic label_error;
  } out_item_t;

endpackage

@@ hw/rtl/rag_pair_mem.sv @@
// Pair mark store: one row per lower label, one 2-bit entry per upper label.
// Row valid flops clear all rows at once; bit-enable writes set marks.
// Depends on rag_pkg.
module rag_pair_mem #(
  parameter int MAX_LABELS = rag_pkg::MAX_LABELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clr,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_LABELS)-1:0] wr_row,
  input  logic [$clog2(MAX_LABELS)-1:0] wr_col,
  input  logic                          wr_bit,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_LABELS)-1:0] rd_row,
  input  logic [$clog2(MAX_LABELS)-1:0] rd_col,
  output logic [1:0]                    rd_mark
);

  typedef logic [MAX_LABELS-1:0][1:0] row_t;

  row_t                  mem [MAX_LABELS];
  logic [MAX_LABELS-1:0] row_ok_r;
  row_t                  fresh_row;
  logic [1:0]            rd_mark_r;
  logic                  rd_ok_r;

  always_comb begin
    fresh_row = '0;
    fresh_row[wr_col][wr_bit] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (row_ok_r[wr_row]) begin
        mem[wr_row][wr_col][wr_bit] <= 1'b1;
      end else begin
        mem[wr_row] <= fresh_row;
      end
    end
    if (rd_en) begin
      rd_mark_r <= mem[rd_row][rd_col];
      rd_ok_r   <= row_ok_r[rd_row];
    end
  end

  // clear wins over a write at the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_ok_r <= '0;
    end else if (clr) begin
      row_ok_r <= '0;
    end else if (wr_en) begin
      row_ok_r[wr_row] <= 1'b1;
    end
  end

  assign rd_mark = rd_ok_r ? rd_mark_r : 2'b00;

endmodule

@@ hw/rtl/region_adjacency_builder.sv @@
// Region adjacency builder, top level: raster neighbor tracking, row buffer,
// mark sequencer and result register. Depends on rag_pkg and rag_pair_mem.
//
// Usage: pixel beats arrive on in_data in raster order (req_type pixel), a
// frame_start beat opening each image and clearing all pair marks. A query
// beat (req_type query) asks for the marks of the pair label/other_label.
// Every accepted beat returns one result beat on out_data; pixels report
// only label_error. The user must write registers on the cfg port only
// while idle; the block itself does not enforce it. A pixel stays in the
// mark stage until all its pair marks (0 to 4) are written, as the mark
// store takes one write per cycle; a query is held at the input while a
// mark is written, since it reads the store when accepted. Peak is one
// beat per cycle when neither these waits nor out_stall hold the input.
// Reset returns the registers to width 1024, 64 labels, diagonal mode on,
// clears all marks at once and restarts the raster position.
// When out_stall holds the result register full, the item in the mark stage
// waits and in_stall rises; nothing is dropped.
module region_adjacency_builder #(
  parameter int MAX_LABELS = rag_pkg::MAX_LABELS_DEF,
  parameter int MAX_WIDTH  = rag_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rag_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output rag_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rag_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int LW = $clog2(MAX_LABELS);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;

  // configuration
  logic [rag_pkg::WIDTH_W-1:0] image_width_r;
  logic [rag_pkg::COUNT_W-1:0] label_count_r;
  logic                        diagonal_enable_r;

  logic [rag_pkg::LIM_W-1:0] lim;
  logic [WW-1:0]             eff_w;

  // raster position
  logic [CW-1:0] column_pos_r, column_pos_nxt;
  logic          pfr_r, pfr_nxt;
  logic [CW-1:0] col_base, col_a;
  logic          pfr_base, pfr_a, wrap;
  logic [WW-1:0] col_inc;
  logic          at_end;

  // row buffer: {ok, label}
  logic [LW:0] row_mem [MAX_WIDTH];
  logic [LW:0] up_rd_r, ur_rd_r;

  // accept
  logic in_acc, pix_acc, qry_acc, ok_a, qerr_a;
  logic [LW-1:0] q_lo, q_hi;

  // mark stage
  logic                        s1_valid_r;
  logic                        s1_req_r;
  logic [rag_pkg::LABEL_W-1:0] s1_label_r, s1_other_r;
  logic                        s1_col_nz_r, s1_pfr_r, s1_ur_use_r, s1_ok_r;
  logic [3:0]                  done_r;

  logic [LW-1:0] left_r, upleft_r;
  logic          left_ok_r, upleft_ok_r;

  logic [LW-1:0] a, nb_sel, m_lo, m_hi;
  logic [LW-1:0] nb [4];
  logic          up_ok, ur_ok, lf_ok, ul_ok;
  logic [3:0]    mark_en, remaining, pick, left_after;
  logic [1:0]    sel;
  logic          found, mark_we, s1_go, out_free;

  logic [1:0]         pm_mark;
  logic               q_err, q_lo_valid, q_hi_valid;
  rag_pkg::out_item_t res;

  logic               out_valid_r;
  rag_pkg::out_item_t out_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r     <= rag_pkg::IMAGE_WIDTH_RST;
      label_count_r     <= rag_pkg::LABEL_COUNT_RST;
      diagonal_enable_r <= rag_pkg::DIAGONAL_ENABLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rag_pkg::REG_IMAGE_WIDTH:     image_width_r     <= cfg_data[rag_pkg::WIDTH_W-1:0];
        rag_pkg::REG_LABEL_COUNT:     label_count_r     <= cfg_data[rag_pkg::COUNT_W-1:0];
        rag_pkg::REG_DIAGONAL_ENABLE: diagonal_enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(label_count_r) < 32'(MAX_LABELS)) begin
      lim = rag_pkg::LIM_W'(label_count_r);
    end else begin
      lim = rag_pkg::LIM_W'(MAX_LABELS);
    end
    if (image_width_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(image_width_r) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width_r);
    end
  end

  // ---------------------------------------------------------------- accept
  assign in_acc  = in_valid && !in_stall;
  assign pix_acc = in_acc && (in_data.req_type == rag_pkg::REQ_PIXEL);
  assign qry_acc = in_acc && (in_data.req_type == rag_pkg::REQ_QUERY);

  always_comb begin
    col_base = in_data.frame_start ? '0 : column_pos_r;
    pfr_base = in_data.frame_start ? 1'b0 : pfr_r;
    wrap     = {1'b0, col_base} >= eff_w;
    col_a    = wrap ? '0 : col_base;
    pfr_a    = wrap || pfr_base;
    col_inc  = {1'b0, col_a} + WW'(1);
    at_end   = col_inc >= eff_w;
    column_pos_nxt = at_end ? '0 : col_inc[CW-1:0];
    pfr_nxt        = at_end || pfr_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_pos_r <= '0;
      pfr_r        <= 1'b0;
    end else if (pix_acc) begin
      column_pos_r <= column_pos_nxt;
      pfr_r        <= pfr_nxt;
    end
  end

  assign ok_a = {1'b0, in_data.label} < lim;

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      row_mem[col_a] <= {ok_a, in_data.label[LW-1:0]};
      up_rd_r        <= row_mem[col_a];
      ur_rd_r        <= row_mem[col_inc[CW-1:0]];
    end
  end

  always_comb begin
    qerr_a = !ok_a || !({1'b0, in_data.other_label} < lim);
    if (qerr_a) begin
      q_lo = '0;
      q_hi = '0;
    end else if (in_data.label < in_data.other_label) begin
      q_lo = in_data.label[LW-1:0];
      q_hi = in_data.other_label[LW-1:0];
    end else begin
      q_lo = in_data.other_label[LW-1:0];
      q_hi = in_data.label[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r    <= in_data.req_type;
      s1_label_r  <= in_data.label;
      s1_other_r  <= in_data.other_label;
      s1_col_nz_r <= col_a != '0;
      s1_pfr_r    <= pfr_a;
      s1_ur_use_r <= !at_end;
      s1_ok_r     <= ok_a;
    end
  end

  // ------------------------------------------------------------ mark stage
  always_comb begin
    a     = s1_label_r[LW-1:0];
    up_ok = s1_pfr_r && up_rd_r[LW];
    ur_ok = s1_pfr_r && s1_ur_use_r && ur_rd_r[LW];
    lf_ok = s1_col_nz_r && left_ok_r;
    ul_ok = s1_col_nz_r && s1_pfr_r && upleft_ok_r;
    nb[0] = left_r;
    nb[1] = up_rd_r[LW-1:0];
    nb[2] = upleft_r;
    nb[3] = ur_rd_r[LW-1:0];
    mark_en[0] = lf_ok && (a != nb[0]);
    mark_en[1] = up_ok && (a != nb[1]);
    mark_en[2] = diagonal_enable_r && ul_ok && (a != nb[2]);
    mark_en[3] = diagonal_enable_r && ur_ok && (a != nb[3]);
    if (!(s1_valid_r && (s1_req_r == rag_pkg::REQ_PIXEL) && s1_ok_r)) begin
      mark_en = '0;
    end
    remaining = mark_en & ~done_r;
    pick  = '0;
    sel   = '0;
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (remaining[i] && !found) begin
        pick[i] = 1'b1;
        sel     = 2'(i);
        found   = 1'b1;
      end
    end
    left_after = remaining & ~pick;
    mark_we    = |remaining;
    nb_sel     = nb[sel];
    m_lo       = (a < nb_sel) ? a : nb_sel;
    m_hi       = (a < nb_sel) ? nb_sel : a;
  end

  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (left_after == '0) && out_free;
  assign in_stall = (s1_valid_r && !s1_go) ||
                    ((in_data.req_type == rag_pkg::REQ_QUERY) && mark_we);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
    end else if (s1_go) begin
      done_r <= '0;
    end else if (mark_we) begin
      done_r <= done_r | pick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_ok_r   <= 1'b0;
      upleft_ok_r <= 1'b0;
    end else if (s1_go && (s1_req_r == rag_pkg::REQ_PIXEL)) begin
      left_ok_r   <= s1_ok_r;
      upleft_ok_r <= up_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && (s1_req_r == rag_pkg::REQ_PIXEL)) begin
      left_r   <= a;
      upleft_r <= up_rd_r[LW-1:0];
    end
  end

  rag_pair_mem #(
    .MAX_LABELS (MAX_LABELS)
  ) u_pair_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (pix_acc && in_data.frame_start),
    .wr_en   (mark_we),
    .wr_row  (m_lo),
    .wr_col  (m_hi),
    .wr_bit  (sel[1] ? rag_pkg::MARK_DIAG : rag_pkg::MARK_ORTH),
    .rd_en   (qry_acc),
    .rd_row  (q_lo),
    .rd_col  (q_hi),
    .rd_mark (pm_mark)
  );

  // ---------------------------------------------------------------- result
  always_comb begin
    q_lo_valid = {1'b0, s1_label_r} < lim;
    q_hi_valid = {1'b0, s1_other_r} < lim;
    q_err      = !q_lo_valid || !q_hi_valid;
    res = '0;
    if (s1_req_r == rag_pkg::REQ_PIXEL) begin
      res.label_error = !s1_ok_r;
    end else if (q_err) begin
      res.label_error = 1'b1;
    end else if (s1_label_r != s1_other_r) begin
      res.adjacent      = pm_mark[rag_pkg::MARK_ORTH] || pm_mark[rag_pkg::MARK_DIAG];
      res.diagonal_only = pm_mark[rag_pkg::MARK_DIAG] && !pm_mark[rag_pkg::MARK_ORTH];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
